[rtl/tss_pkg.sv]
package tss_pkg;

    // Defaults for the top-level parameters
    localparam int LIST_DEPTH_DEF   = 64;
    localparam int SINE_ENTRIES_DEF = 256;
    localparam int PHASE_BITS_DEF   = 32;

    // Queue depths between the front, the sequencer and the output
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 8;

    // Field widths
    localparam int FREQ_W   = 15;
    localparam int LEN_W    = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 32;
    localparam int MUL_W    = FREQ_W + CFG_W;

    // Register reset values and full scale of the sine table
    localparam logic [CFG_W-1:0] STEP_PER_HZ_RESET = 32'd97392;
    localparam logic [AMP_W-1:0] AMP_RESET         = 15'd32000;
    localparam logic [15:0]      Q15_MAX           = 16'd32767;

    // Fixed-point constants for the sine table build
    localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] Q30_HALF    = 64'h0000_0000_2000_0000;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_LOAD_MAIN = 3'd1,
        CMD_LOAD_SUB  = 3'd2,
        CMD_STOP_MAIN = 3'd3,
        CMD_STOP_SUB  = 3'd4
    } cmd_code_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_STEP_PER_HZ = 1'b0,
        REG_AMPLITUDE   = 1'b1
    } reg_idx_t;

    // Operations handed from the front to the sequencer
    typedef enum logic [1:0] {
        OP_TICK,
        OP_LOAD,
        OP_STOP
    } op_t;

    // Which list the current tone came from
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_MAIN,
        SRC_SUB
    } src_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [FREQ_W-1:0] freq;
    } tone_t;

    typedef struct packed {
        op_t   op;
        logic  sel_sub;
        logic  first;
        logic  ms;
        tone_t tone;
    } cmd_t;

    typedef struct packed {
        logic gate;
        logic playing_sub;
    } voice_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sound_on;
        logic                       playing_sub;
    } out_t;

endpackage

[rtl/tss_fifo.sv]
module tss_fifo
    import tss_pkg::*;
#(
    parameter int WIDTH = $bits(cmd_t),
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap at any depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/tss_front.sv]
module tss_front
    import tss_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic              s_first_tone,
    input  logic [FREQ_W-1:0] s_tone_freq,
    input  logic [LEN_W-1:0]  s_tone_length_ms,
    input  logic              s_ms_boundary,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_data
);

    logic known;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && known;

    // Classify the command; drop codes that mean nothing
    always_comb begin
        known             = 1'b1;
        q_data.op         = OP_TICK;
        q_data.sel_sub    = 1'b0;
        q_data.first      = s_first_tone;
        q_data.ms         = s_ms_boundary;
        q_data.tone.freq  = s_tone_freq;
        q_data.tone.len   = s_tone_length_ms;
        case (cmd_code_t'(s_command))
            CMD_TICK:      q_data.op = OP_TICK;
            CMD_LOAD_MAIN: q_data.op = OP_LOAD;
            CMD_LOAD_SUB: begin
                q_data.op      = OP_LOAD;
                q_data.sel_sub = 1'b1;
            end
            CMD_STOP_MAIN: q_data.op = OP_STOP;
            CMD_STOP_SUB: begin
                q_data.op      = OP_STOP;
                q_data.sel_sub = 1'b1;
            end
            default:       known = 1'b0;
        endcase
    end

endmodule

[rtl/tss_seq.sv]
module tss_seq
    import tss_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic [CFG_W-1:0]      phase_step_per_hz,
    output logic                  job_valid,
    input  logic                  job_ready,
    output logic [PHASE_BITS-1:0] job_phase,
    output voice_ctl_t            job_ctl
);

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_APPLY
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         main_count_reg, main_count_next;
    logic [CW-1:0]         sub_count_reg, sub_count_next;
    logic [PW-1:0]         main_pos_reg, main_pos_next;
    logic [PW-1:0]         sub_pos_reg, sub_pos_next;
    logic [LEN_W-1:0]      remaining_reg, remaining_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  gate_reg, gate_next;
    src_t                  src_reg, src_next;

    tone_t                 main_mem [LIST_DEPTH];
    tone_t                 sub_mem [LIST_DEPTH];
    tone_t                 main_rd_reg, sub_rd_reg, sel_tone;
    logic [PHASE_BITS-1:0] step_prod_reg, step_use;

    // Boundary view: list state after the pending advance
    logic [CW-1:0] mc_a, sc_a, mp_a, sp_a;
    logic          gate_a;
    src_t          src_a;

    logic          main_we, sub_we;
    logic [PW-1:0] wr_addr;
    logic [CW-1:0] load_cnt;

    assign job_phase = phase_reg;
    assign job_ctl   = '{gate: gate_reg, playing_sub: (src_reg == SRC_SUB)};
    assign sel_tone  = (src_reg == SRC_SUB) ? sub_rd_reg : main_rd_reg;

    // Do the pending advance, then pick the next list
    always_comb begin
        mc_a   = main_count_reg;
        sc_a   = sub_count_reg;
        mp_a   = CW'(main_pos_reg);
        sp_a   = CW'(sub_pos_reg);
        src_a  = SRC_NONE;
        case (src_reg)
            SRC_MAIN: begin
                mp_a = mp_a + CW'(1);
                if (mp_a >= mc_a) mp_a = '0;
            end
            SRC_SUB: begin
                sp_a = sp_a + CW'(1);
                if (sp_a >= sc_a) begin
                    sc_a = '0;
                    sp_a = '0;
                end
            end
            default: ;
        endcase
        gate_a = (mc_a != '0) || (sc_a != '0);
        if (sc_a != '0) begin
            if (sp_a >= sc_a) sp_a = '0;
            src_a = SRC_SUB;
        end else if (mc_a != '0) begin
            if (mp_a >= mc_a) mp_a = '0;
            src_a = SRC_MAIN;
        end
    end

    // Execute the item at the queue head
    always_comb begin
        state_next      = state_reg;
        main_count_next = main_count_reg;
        sub_count_next  = sub_count_reg;
        main_pos_next   = main_pos_reg;
        sub_pos_next    = sub_pos_reg;
        remaining_next  = remaining_reg;
        phase_step_next = phase_step_reg;
        phase_next      = phase_reg;
        gate_next       = gate_reg;
        src_next        = src_reg;
        cmd_pop         = 1'b0;
        job_valid       = 1'b0;
        main_we         = 1'b0;
        sub_we          = 1'b0;
        load_cnt        = '0;
        step_use        = (src_reg != SRC_NONE) ? step_prod_reg : phase_step_reg;
        case (state_reg)
            ST_RUN: begin
                if (cmd_valid) begin
                    case (cmd.op)
                        OP_LOAD: begin
                            cmd_pop = 1'b1;
                            if (cmd.sel_sub) begin
                                load_cnt = cmd.first ? '0 : sub_count_reg;
                                if (cmd.first) begin
                                    sub_pos_next = '0;
                                    if (src_reg == SRC_SUB) src_next = SRC_NONE;
                                end
                                sub_count_next = load_cnt;
                                if (load_cnt < CW'(LIST_DEPTH)) begin
                                    sub_we         = 1'b1;
                                    sub_count_next = load_cnt + CW'(1);
                                end
                            end else begin
                                load_cnt = cmd.first ? '0 : main_count_reg;
                                if (cmd.first) begin
                                    main_pos_next = '0;
                                    if (src_reg == SRC_MAIN) src_next = SRC_NONE;
                                end
                                main_count_next = load_cnt;
                                if (load_cnt < CW'(LIST_DEPTH)) begin
                                    main_we         = 1'b1;
                                    main_count_next = load_cnt + CW'(1);
                                end
                            end
                        end
                        OP_STOP: begin
                            cmd_pop = 1'b1;
                            if (cmd.sel_sub) begin
                                sub_count_next = '0;
                                sub_pos_next   = '0;
                                if (src_reg == SRC_SUB) src_next = SRC_NONE;
                            end else begin
                                main_count_next = '0;
                                main_pos_next   = '0;
                                if (src_reg == SRC_MAIN) src_next = SRC_NONE;
                            end
                        end
                        OP_TICK: begin
                            if (remaining_reg == '0) begin
                                // Commit the boundary and start the list read
                                main_count_next = mc_a;
                                sub_count_next  = sc_a;
                                main_pos_next   = PW'(mp_a);
                                sub_pos_next    = PW'(sp_a);
                                gate_next       = gate_a;
                                src_next        = src_a;
                                state_next      = ST_MUL;
                            end else if (job_ready) begin
                                job_valid  = 1'b1;
                                cmd_pop    = 1'b1;
                                phase_next = phase_reg + phase_step_reg;
                                if (cmd.ms) remaining_next = remaining_reg - LEN_W'(1);
                            end
                        end
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_MUL: begin
                if (src_reg != SRC_NONE) remaining_next = sel_tone.len;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (job_ready) begin
                    phase_step_next = step_use;
                    phase_next      = phase_reg + step_use;
                    job_valid       = 1'b1;
                    cmd_pop         = 1'b1;
                    state_next      = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    assign wr_addr = PW'(load_cnt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            main_count_reg <= '0;
            sub_count_reg  <= '0;
            main_pos_reg   <= '0;
            sub_pos_reg    <= '0;
            remaining_reg  <= '0;
            phase_step_reg <= '0;
            phase_reg      <= '0;
            gate_reg       <= 1'b0;
            src_reg        <= SRC_NONE;
        end else begin
            state_reg      <= state_next;
            main_count_reg <= main_count_next;
            sub_count_reg  <= sub_count_next;
            main_pos_reg   <= main_pos_next;
            sub_pos_reg    <= sub_pos_next;
            remaining_reg  <= remaining_next;
            phase_step_reg <= phase_step_next;
            phase_reg      <= phase_next;
            gate_reg       <= gate_next;
            src_reg        <= src_next;
        end
    end

    // Tone lists: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (main_we) main_mem[wr_addr] <= cmd.tone;
        if (sub_we) sub_mem[wr_addr] <= cmd.tone;
        main_rd_reg <= main_mem[PW'(mp_a)];
        sub_rd_reg  <= sub_mem[PW'(sp_a)];
    end

    // Scale the tone frequency to a phase step
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            step_prod_reg <= PHASE_BITS'(MUL_W'(sel_tone.freq) * MUL_W'(phase_step_per_hz));
        end
    end

endmodule

[rtl/tss_voice.sv]
module tss_voice
    import tss_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  logic [PHASE_BITS-1:0]      job_phase,
    input  voice_ctl_t                 job_ctl,
    input  logic [AMP_W-1:0]           amplitude,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_sound_on,
    output logic                       m_playing_sub
);

    localparam int IW  = $clog2(SINE_ENTRIES);
    localparam int SW  = PHASE_BITS + IW;
    localparam int PRW = 2 * AMP_W;
    localparam int KW  = $clog2(OUT_QUEUE_DEPTH + 1);

    typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Q15 magnitude of the sine of f quarter-table steps
    function automatic logic [AMP_W-1:0] quarter_sine(input logic [63:0] f);
        logic [63:0] x, x2, t, s, q;
        x  = (f * Q30_HALF_PI) / SINE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s * 64'd32767 + Q30_HALF) >> 30;
        return (q > 64'd32767) ? AMP_W'(32767) : q[AMP_W-1:0];
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t             rom;
        logic [63:0]           t4, quad, f;
        logic [AMP_W-1:0]      v;
        logic signed [SAMPLE_W-1:0] sv;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            t4   = 64'(4 * k);
            quad = t4 / SINE_ENTRIES;
            f    = t4 - quad * SINE_ENTRIES;
            v    = quad[0] ? quarter_sine(64'(SINE_ENTRIES) - f) : quarter_sine(f);
            sv   = $signed({1'b0, v});
            rom[IW'(k)] = (quad >= 64'd2) ? -sv : sv;
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    logic                       v1_reg, v2_reg, v3_reg;
    logic [IW-1:0]              idx_reg;
    logic signed [SAMPLE_W-1:0] rom_reg;
    logic [PRW-1:0]             prod_reg;
    logic                       neg_reg;
    voice_ctl_t                 ctl1_reg, ctl2_reg, ctl3_reg;
    logic [KW-1:0]              credit_reg, credit_next;

    logic [SW-1:0]       scaled;
    logic                neg;
    logic [AMP_W-1:0]    mag;
    logic [AMP_W-1:0]    q0;
    logic [SAMPLE_W-1:0] rem, mq;
    out_t                out_item, out_head;
    logic                issue, out_pop, out_full, out_empty;

    assign issue     = job_valid && job_ready;
    assign job_ready = (credit_reg < KW'(OUT_QUEUE_DEPTH));

    // Count items in flight plus items waiting at the output
    always_comb begin
        case ({issue, out_pop})
            2'b10:   credit_next = credit_reg + KW'(1);
            2'b01:   credit_next = credit_reg - KW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            credit_reg <= '0;
        end else begin
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            credit_reg <= credit_next;
        end
    end

    // Map the phase onto a table index
    assign scaled = SW'(job_phase) * SW'(SINE_ENTRIES);

    assign neg = rom_reg[SAMPLE_W-1];
    assign mag = AMP_W'(neg ? -rom_reg : rom_reg);

    // Stages: index, table read, amplitude product
    always_ff @(posedge aclk) begin
        idx_reg  <= scaled[SW-1:PHASE_BITS];
        ctl1_reg <= job_ctl;
        rom_reg  <= SINE_ROM[idx_reg];
        ctl2_reg <= ctl1_reg;
        prod_reg <= PRW'(amplitude) * PRW'(mag);
        neg_reg  <= neg;
        ctl3_reg <= ctl2_reg;
    end

    // Divide the product by full scale: quotient estimate plus one correction
    assign q0  = prod_reg[PRW-1:AMP_W];
    assign rem = {1'b0, prod_reg[AMP_W-1:0]} + {1'b0, q0};
    assign mq  = {1'b0, q0} + SAMPLE_W'(rem >= Q15_MAX);

    always_comb begin
        out_item.sound_on    = ctl3_reg.gate;
        out_item.playing_sub = ctl3_reg.playing_sub;
        if (!ctl3_reg.gate) begin
            out_item.sample = '0;
        end else if (neg_reg) begin
            out_item.sample = -$signed(mq);
        end else begin
            out_item.sample = $signed(mq);
        end
    end

    // Hold results until the receiver takes them
    tss_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v3_reg),
        .push_data (out_item),
        .full      (out_full),
        .pop       (out_pop),
        .pop_data  (out_head),
        .empty     (out_empty)
    );

    assign m_valid       = !out_empty;
    assign out_pop       = m_valid && m_ready && !(out_full && 1'b0);
    assign m_sample      = out_head.sample;
    assign m_sound_on    = out_head.sound_on;
    assign m_playing_sub = out_head.playing_sub;

endmodule

[rtl/tone_sequencer_sine_synth.sv]
// Tone sequencer with a direct-digital-synthesis sine voice.
// Input channel (s_*): commands with valid/ready. A load appends a tone
// (frequency, length in ms) to the main or sub list, a stop empties a list,
// and a sample tick advances time by one sample and yields one result on the
// m_* channel (sample, sound_on, playing_sub). Other commands give no result.
// Config port (cfg_we/cfg_index/cfg_wdata) sets the phase step per hertz and
// the amplitude; write it only while the block is idle.
// Flow: commands pass a 4-entry queue into the sequencer. A load, a stop or
// a tick inside a tone is done in the run state; a tick at a tone boundary
// also passes the multiply and apply states (registered list memory read,
// then the frequency multiply). A tick waits while the voice is not ready.
// Each result passes the index, table and multiply registers and a divide.
// Reset clears both lists, the tone timer and the phase; the first tick is a
// boundary. When the receiver stalls, up to 8 results wait in the output
// queue; the sequencer then holds its tick and the command queue fills until
// s_ready drops.
module tone_sequencer_sine_synth
    import tss_pkg::*;
#(
    parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_command,
    input  logic                       s_first_tone,
    input  logic [FREQ_W-1:0]          s_tone_freq,
    input  logic [LEN_W-1:0]           s_tone_length_ms,
    input  logic                       s_ms_boundary,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_sound_on,
    output logic                       m_playing_sub,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_wdata
);

    logic [CFG_W-1:0]      step_per_hz_reg;
    logic [AMP_W-1:0]      amplitude_reg;

    logic                  q_push, q_full, q_pop, q_empty;
    cmd_t                  q_in, q_head;
    logic                  job_valid, job_ready;
    logic [PHASE_BITS-1:0] job_phase;
    voice_ctl_t            job_ctl;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_per_hz_reg <= STEP_PER_HZ_RESET;
            amplitude_reg   <= AMP_RESET;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_STEP_PER_HZ: step_per_hz_reg <= cfg_wdata;
                REG_AMPLITUDE:   amplitude_reg   <= cfg_wdata[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    tss_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_first_tone     (s_first_tone),
        .s_tone_freq      (s_tone_freq),
        .s_tone_length_ms (s_tone_length_ms),
        .s_ms_boundary    (s_ms_boundary),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_in)
    );

    tss_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    tss_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (!q_empty),
        .cmd               (q_head),
        .cmd_pop           (q_pop),
        .phase_step_per_hz (step_per_hz_reg),
        .job_valid         (job_valid),
        .job_ready         (job_ready),
        .job_phase         (job_phase),
        .job_ctl           (job_ctl)
    );

    tss_voice #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .PHASE_BITS   (PHASE_BITS)
    ) u_voice (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job_phase     (job_phase),
        .job_ctl       (job_ctl),
        .amplitude     (amplitude_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_sound_on    (m_sound_on),
        .m_playing_sub (m_playing_sub)
    );

endmodule
